// ===== design/xsf_pkg.sv =====
package xsf_pkg;

  localparam int CALC_W = 17;
  localparam int SCR_W_W = 8;
  localparam int SCR_H_W = 7;
  localparam int ROW_PIX_FIELD_W = 16;

  localparam logic [SCR_W_W-1:0] SCREEN_WIDTH_RST = 8'd64;
  localparam logic [SCR_H_W-1:0] SCREEN_HEIGHT_RST = 7'd32;

  localparam logic PX_DARK = 1'b0;
  localparam logic PX_LIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_PRESENT = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t             kind;
    logic [CALC_W-1:0] addr;
    logic              last;
  } q_ctrl_t;

endpackage

// ===== design/xor_sprite_framebuffer.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_kind, in_pos_x, in_pos_y, in_row_index, in_row_width,
//                                 in_row_pixels, in_last_row, in_read_index
// out      out_valid / out_stall  out_collision, out_sprite_done, out_pixel
// cfg      cfg_we                 cfg_index, cfg_data
//
// A draw beat reads the two banked back-buffer word memories, then XORs and writes back;
// a read beat reads the banked display memories. Clear zeroes the back buffer and present
// copies it to the display row by row, over MAX_PIXELS / (2 * word width) rows per bank
// rounded up to a power of two (256 at the default sizes). After reset and after every
// register write a clearing pass zeroes both buffers, with in_stall high. A two-entry queue
// decouples in_stall from out_stall: inputs are taken while a result waits, until it fills.
module xor_sprite_framebuffer #(
  parameter int MAX_PIXELS = 8192,
  parameter int MAX_ROW_PIXELS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_kind,
  input  logic [6:0]   in_pos_x,
  input  logic [5:0]   in_pos_y,
  input  logic [3:0]   in_row_index,
  input  logic [4:0]   in_row_width,
  input  logic [15:0]  in_row_pixels,
  input  logic         in_last_row,
  input  logic [12:0]  in_read_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_collision,
  output logic         out_sprite_done,
  output logic         out_pixel
);

  localparam int WORD_W = 1 << $clog2(MAX_ROW_PIXELS);
  localparam int CW = xsf_pkg::CALC_W;

  logic [xsf_pkg::SCR_W_W-1:0]  width_r, width_nxt;
  logic [xsf_pkg::SCR_H_W-1:0]  height_r, height_nxt;
  logic [CW-1:0]                size_r, size_nxt;
  logic [14:0]                  area;

  logic                         q_push;
  xsf_pkg::q_ctrl_t             push_ctrl;
  logic [WORD_W-1:0]            push_pix;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  xsf_pkg::q_ctrl_t             head_ctrl;
  logic [WORD_W-1:0]            head_pix;
  logic                         init_busy;

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (xsf_pkg::cfg_reg_t'(cfg_index))
        xsf_pkg::CFG_SCREEN_WIDTH: width_nxt = cfg_data;
        xsf_pkg::CFG_SCREEN_HEIGHT: height_nxt = cfg_data[xsf_pkg::SCR_H_W-1:0];
      endcase
    end
    area = 15'(width_r) * 15'(height_r);
    size_nxt = (CW'(area) > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(area);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= xsf_pkg::SCREEN_WIDTH_RST;
      height_r <= xsf_pkg::SCREEN_HEIGHT_RST;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
  end

  xsf_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .WORD_W(WORD_W)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_row_index(in_row_index),
    .in_row_width(in_row_width),
    .in_row_pixels(in_row_pixels),
    .in_last_row(in_last_row),
    .in_read_index(in_read_index),
    .screen_width(width_r),
    .busy(init_busy),
    .q_full(q_full),
    .q_push(q_push),
    .q_ctrl(push_ctrl),
    .q_pix(push_pix)
  );

  xsf_queue #(
    .PIX_W(WORD_W)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_ctrl(push_ctrl),
    .push_pix(push_pix),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_ctrl(head_ctrl),
    .head_pix(head_pix)
  );

  xsf_back #(
    .MAX_PIXELS(MAX_PIXELS),
    .WORD_W(WORD_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_clear(cfg_we),
    .size(size_r),
    .q_valid(q_valid),
    .q_ctrl(head_ctrl),
    .q_pix(head_pix),
    .q_pop(q_pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_collision(out_collision),
    .out_sprite_done(out_sprite_done),
    .out_pixel(out_pixel)
  );

endmodule

// ===== design/xsf_front.sv =====
module xsf_front #(
  parameter int MAX_ROW_PIXELS = 16,
  parameter int WORD_W = 16
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [6:0]                    in_pos_x,
  input  logic [5:0]                    in_pos_y,
  input  logic [3:0]                    in_row_index,
  input  logic [4:0]                    in_row_width,
  input  logic [15:0]                   in_row_pixels,
  input  logic                          in_last_row,
  input  logic [12:0]                   in_read_index,
  input  logic [xsf_pkg::SCR_W_W-1:0]   screen_width,
  input  logic                          busy,
  input  logic                          q_full,
  output logic                          q_push,
  output xsf_pkg::q_ctrl_t              q_ctrl,
  output logic [WORD_W-1:0]             q_pix
);

  logic [6:0]                   line;
  logic [14:0]                  prod;
  logic [xsf_pkg::CALC_W-1:0]   base;
  logic [63:0]                  pix_ext;
  logic [WORD_W-1:0]            row_mask;
  xsf_pkg::kind_t               kind;

  assign in_stall = q_full || busy;
  assign q_push = in_valid && !in_stall;
  assign kind = xsf_pkg::kind_t'(in_kind);

  always_comb begin
    line = 7'(in_pos_y) + 7'(in_row_index);
    prod = 15'(screen_width) * 15'(line);
    base = xsf_pkg::CALC_W'(prod) + xsf_pkg::CALC_W'(in_pos_x);
    pix_ext = 64'(in_row_pixels);
    for (int j = 0; j < WORD_W; j++) begin
      row_mask[j] = (j < int'(in_row_width)) && (j < MAX_ROW_PIXELS);
    end
    q_pix = pix_ext[WORD_W-1:0] & row_mask;
    q_ctrl.kind = kind;
    q_ctrl.last = in_last_row;
    if (kind == xsf_pkg::KIND_READ) begin
      q_ctrl.addr = xsf_pkg::CALC_W'(in_read_index);
    end else begin
      q_ctrl.addr = base;
    end
  end

endmodule

// ===== design/xsf_queue.sv =====
module xsf_queue #(
  parameter int PIX_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xsf_pkg::q_ctrl_t  push_ctrl,
  input  logic [PIX_W-1:0]  push_pix,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output xsf_pkg::q_ctrl_t  head_ctrl,
  output logic [PIX_W-1:0]  head_pix
);

  xsf_pkg::q_ctrl_t  ctrl_r [2];
  logic [PIX_W-1:0]  pix_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_pop;

  assign full = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_ctrl = ctrl_r[rd_ptr_r];
  assign head_pix = pix_r[rd_ptr_r];
  assign do_pop = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_r[wr_ptr_r] <= push_ctrl;
      pix_r[wr_ptr_r] <= push_pix;
    end
  end

endmodule

// ===== design/xsf_back.sv =====
module xsf_back #(
  parameter int MAX_PIXELS = 8192,
  parameter int WORD_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_clear,
  input  logic [xsf_pkg::CALC_W-1:0]  size,
  input  logic                        q_valid,
  input  xsf_pkg::q_ctrl_t            q_ctrl,
  input  logic [WORD_W-1:0]           q_pix,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_collision,
  output logic                        out_sprite_done,
  output logic                        out_pixel
);

  localparam int WORD_SH = $clog2(WORD_W);
  localparam int NWORDS = (MAX_PIXELS + WORD_W - 1) / WORD_W;
  localparam int ROWS = (NWORDS + 1) / 2;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = 1 << ROW_AW;
  localparam int CW = xsf_pkg::CALC_W;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_EXEC = 6'b000100,
    S_CLR  = 6'b001000,
    S_COPY = 6'b010000,
    S_POST = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ROW_AW:0]        cnt_r, cnt_nxt;
  logic                   hit_r, hit_nxt;
  xsf_pkg::kind_t         kind_r, kind_nxt;
  logic                   last_r, last_nxt;
  logic [2*WORD_W-1:0]    win_r, win_nxt;
  logic                   k0_r, k0_nxt;
  logic [WORD_SH-1:0]     off_r, off_nxt;
  logic                   ok_r, ok_nxt;
  logic [ROW_AW-1:0]      row_e_r, row_e_nxt;
  logic [ROW_AW-1:0]      row_o_r, row_o_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_col_r, out_col_nxt;
  logic                   out_done_r, out_done_nxt;
  logic                   out_pix_r, out_pix_nxt;

  logic                   bk_re [2];
  logic [ROW_AW-1:0]      bk_ra [2];
  logic                   bk_we [2];
  logic [ROW_AW-1:0]      bk_wa [2];
  logic [WORD_W-1:0]      bk_wd [2];
  logic [WORD_W-1:0]      bk_rd_r [2];
  logic                   dp_re [2];
  logic [ROW_AW-1:0]      dp_ra [2];
  logic                   dp_we [2];
  logic [ROW_AW-1:0]      dp_wa [2];
  logic [WORD_W-1:0]      dp_wd [2];
  logic [WORD_W-1:0]      dp_rd_r [2];

  logic [CW-WORD_SH-1:0]  h_word;
  logic [ROW_AW-1:0]      h_row_o;
  logic [ROW_AW-1:0]      h_row_e;
  logic [CW-1:0]          lim;
  logic [WORD_W-1:0]      pm;
  logic [WORD_W-1:0]      wb [2];
  logic [WORD_W-1:0]      rd_word;
  logic                   coll;
  logic                   out_free;
  logic                   out_load;

  assign out_free = !out_valid_r || !out_stall;
  assign init_busy = (state_r == S_INIT);
  assign out_valid = out_valid_r;
  assign out_collision = out_col_r;
  assign out_sprite_done = out_done_r;
  assign out_pixel = out_pix_r;

  always_comb begin
    h_word = q_ctrl.addr[CW-1:WORD_SH];
    h_row_o = h_word[ROW_AW:1];
    h_row_e = h_row_o + ROW_AW'(h_word[0]);
    lim = (size > q_ctrl.addr) ? (size - q_ctrl.addr) : '0;
    for (int j = 0; j < WORD_W; j++) begin
      pm[j] = q_pix[j] & (CW'(j) < lim);
    end
    wb[0] = k0_r ? win_r[2*WORD_W-1:WORD_W] : win_r[WORD_W-1:0];
    wb[1] = k0_r ? win_r[WORD_W-1:0] : win_r[2*WORD_W-1:WORD_W];
    coll = |((bk_rd_r[0] & wb[0]) | (bk_rd_r[1] & wb[1]));
    rd_word = k0_r ? dp_rd_r[1] : dp_rd_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    win_nxt = win_r;
    k0_nxt = k0_r;
    off_nxt = off_r;
    ok_nxt = ok_r;
    row_e_nxt = row_e_r;
    row_o_nxt = row_o_r;
    q_pop = 1'b0;
    out_load = 1'b0;
    out_col_nxt = out_col_r;
    out_done_nxt = out_done_r;
    out_pix_nxt = out_pix_r;
    for (int b = 0; b < 2; b++) begin
      bk_re[b] = 1'b0;
      bk_ra[b] = '0;
      bk_we[b] = 1'b0;
      bk_wa[b] = '0;
      bk_wd[b] = '0;
      dp_re[b] = 1'b0;
      dp_ra[b] = '0;
      dp_we[b] = 1'b0;
      dp_wa[b] = '0;
      dp_wd[b] = '0;
    end

    unique case (state_r)
      S_INIT: begin
        for (int b = 0; b < 2; b++) begin
          bk_we[b] = 1'b1;
          bk_wa[b] = cnt_r[ROW_AW-1:0];
          bk_wd[b] = {WORD_W{xsf_pkg::PX_DARK}};
          dp_we[b] = 1'b1;
          dp_wa[b] = cnt_r[ROW_AW-1:0];
          dp_wd[b] = {WORD_W{xsf_pkg::PX_DARK}};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ROW_AW+1)'(DEPTH - 1)) begin
          cnt_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          kind_nxt = q_ctrl.kind;
          last_nxt = q_ctrl.last;
          win_nxt = (2*WORD_W)'(pm) << q_ctrl.addr[WORD_SH-1:0];
          k0_nxt = h_word[0];
          off_nxt = q_ctrl.addr[WORD_SH-1:0];
          ok_nxt = (q_ctrl.addr < size);
          row_e_nxt = h_row_e;
          row_o_nxt = h_row_o;
          cnt_nxt = '0;
          unique case (q_ctrl.kind)
            xsf_pkg::KIND_DRAW: begin
              bk_re[0] = 1'b1;
              bk_re[1] = 1'b1;
              bk_ra[0] = h_row_e;
              bk_ra[1] = h_row_o;
              state_nxt = S_EXEC;
            end
            xsf_pkg::KIND_READ: begin
              dp_re[0] = 1'b1;
              dp_re[1] = 1'b1;
              dp_ra[0] = h_row_e;
              dp_ra[1] = h_row_o;
              state_nxt = S_EXEC;
            end
            xsf_pkg::KIND_CLEAR: state_nxt = S_CLR;
            xsf_pkg::KIND_PRESENT: state_nxt = S_COPY;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
          if (kind_r == xsf_pkg::KIND_DRAW) begin
            bk_we[0] = 1'b1;
            bk_we[1] = 1'b1;
            bk_wa[0] = row_e_r;
            bk_wa[1] = row_o_r;
            bk_wd[0] = bk_rd_r[0] ^ wb[0];
            bk_wd[1] = bk_rd_r[1] ^ wb[1];
            out_col_nxt = hit_r | coll;
            out_done_nxt = last_r;
            out_pix_nxt = xsf_pkg::PX_DARK;
            hit_nxt = last_r ? 1'b0 : (hit_r | coll);
          end else begin
            out_col_nxt = 1'b0;
            out_done_nxt = 1'b0;
            out_pix_nxt = rd_word[off_r] & ok_r;
          end
        end
      end
      S_CLR: begin
        bk_we[0] = 1'b1;
        bk_we[1] = 1'b1;
        bk_wa[0] = cnt_r[ROW_AW-1:0];
        bk_wa[1] = cnt_r[ROW_AW-1:0];
        bk_wd[0] = {WORD_W{xsf_pkg::PX_DARK}};
        bk_wd[1] = {WORD_W{xsf_pkg::PX_DARK}};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ROW_AW+1)'(DEPTH - 1)) begin
          state_nxt = S_POST;
        end
      end
      S_COPY: begin
        if (cnt_r != (ROW_AW+1)'(DEPTH)) begin
          bk_re[0] = 1'b1;
          bk_re[1] = 1'b1;
          bk_ra[0] = cnt_r[ROW_AW-1:0];
          bk_ra[1] = cnt_r[ROW_AW-1:0];
        end
        if (cnt_r != '0) begin
          for (int b = 0; b < 2; b++) begin
            dp_we[b] = 1'b1;
            dp_wa[b] = ROW_AW'(cnt_r - 1'b1);
            dp_wd[b] = bk_rd_r[b];
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (ROW_AW+1)'(DEPTH)) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_col_nxt = 1'b0;
          out_done_nxt = 1'b0;
          out_pix_nxt = xsf_pkg::PX_DARK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase

    if (cfg_clear) begin
      state_nxt = S_INIT;
      cnt_nxt = '0;
      hit_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r <= '0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      hit_r <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    last_r <= last_nxt;
    win_r <= win_nxt;
    k0_r <= k0_nxt;
    off_r <= off_nxt;
    ok_r <= ok_nxt;
    row_e_r <= row_e_nxt;
    row_o_r <= row_o_nxt;
    out_col_r <= out_col_nxt;
    out_done_r <= out_done_nxt;
    out_pix_r <= out_pix_nxt;
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [WORD_W-1:0] back_mem [DEPTH];
    logic [WORD_W-1:0] disp_mem [DEPTH];

    always_ff @(posedge clk) begin
      if (bk_we[b]) begin
        back_mem[bk_wa[b]] <= bk_wd[b];
      end
      if (bk_re[b]) begin
        bk_rd_r[b] <= back_mem[bk_ra[b]];
      end
    end

    always_ff @(posedge clk) begin
      if (dp_we[b]) begin
        disp_mem[dp_wa[b]] <= dp_wd[b];
      end
      if (dp_re[b]) begin
        dp_rd_r[b] <= disp_mem[dp_ra[b]];
      end
    end
  end

  a_cfg_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> state_r == S_INIT)
    else $error("register write did not start the clearing pass");

  a_last_row_clears_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && kind_r == xsf_pkg::KIND_DRAW && last_r && out_free && !cfg_clear)
    |=> !hit_r)
    else $error("collision flag survived the last row of a sprite");

  a_read_leaves_back: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && kind_r == xsf_pkg::KIND_READ) |-> !bk_we[0] && !bk_we[1])
    else $error("pixel read wrote the back buffer");

endmodule

// ===== test/xor_sprite_framebuffer_tb.sv =====
module xor_sprite_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB_PIXELS = 8192;
  localparam int ROW_MAX = 16;
  localparam int PHASES = 7;
  localparam int RAND_PER_PHASE = 220;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SHOW_MAX = 30;

  localparam int SET_W [PHASES] = '{128, 1, 0, 255, 64, 23, 64};
  localparam int SET_H [PHASES] = '{64, 1, 32, 127, 0, 11, 32};
  localparam int GAP_PCT [PHASES] = '{25, 0, 5, 10, 25, 5, 0};
  localparam int HOLD_PCT [PHASES] = '{10, 25, 0, 5, 25, 10, 0};

  typedef struct packed {
    xsf_pkg::kind_t kind;
    logic [6:0]     px;
    logic [5:0]     py;
    logic [3:0]     row;
    logic [4:0]     rw;
    logic [15:0]    bits;
    logic           last;
    logic [12:0]    ridx;
  } beat_t;

  typedef struct packed {
    logic coll;
    logic done;
    logic pix;
  } outcome_t;

  typedef struct packed {
    beat_t    b;
    logic     fixed;
    outcome_t want;
  } plan_row_t;

  localparam int DIR_N = 25;
  localparam plan_row_t PLAN [DIR_N] = '{
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'h0000}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h7F, 6'h3F, 4'hF, 5'h1F, 16'hFFFF, 1'b1, 13'h1FFF}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd0, 4'd0, 5'd16, 16'hFFFF, 1'b0, 13'h0000}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd0, 4'd0, 5'd16, 16'hFFFF, 1'b1, 13'h0000}, 1'b1, 3'b110},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1, 13'h0000}, 1'b1, 3'b010},
    '{'{xsf_pkg::KIND_DRAW, 7'd127, 6'd0, 4'd0, 5'd16, 16'hA5A5, 1'b0, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd127, 6'd0, 4'd1, 5'd31, 16'hFFFF, 1'b1, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd63, 4'd15, 5'd16, 16'hFFFF, 1'b1, 13'h0000}, 1'b1, 3'b010},
    '{'{xsf_pkg::KIND_DRAW, 7'd64, 6'd31, 4'd0, 5'd16, 16'hFFFF, 1'b0, 13'h0000}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd48, 6'd31, 4'd0, 5'd16, 16'hFFFF, 1'b1, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_PRESENT, 7'h55, 6'h2A, 4'hA, 5'h15, 16'h5A5A, 1'b1, 13'h0AAA}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'd127}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'd2047}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'd2048}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_CLEAR, 7'h2A, 6'h15, 4'h5, 5'h0A, 16'hA5A5, 1'b0, 13'h1555}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'd127}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_PRESENT, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'h0000}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'd127}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'h55, 6'h2A, 4'hA, 5'h0A, 16'h5555, 1'b0, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'h2A, 6'h15, 4'h5, 5'h15, 16'hAAAA, 1'b0, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'h2A, 6'h15, 4'h5, 5'h10, 16'hFFFF, 1'b0, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_READ, 7'h2A, 6'h15, 4'h5, 5'h0A, 16'h5A5A, 1'b1, 13'h0AAA}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_CLEAR, 7'h00, 6'h00, 4'h0, 5'h00, 16'h0000, 1'b0, 13'h0000}, 1'b1, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd0, 4'd0, 5'd0, 16'hFFFF, 1'b1, 13'h0000}, 1'b0, 3'b000},
    '{'{xsf_pkg::KIND_DRAW, 7'd0, 6'd0, 4'd0, 5'd16, 16'h0000, 1'b1, 13'h0000}, 1'b1, 3'b010}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [6:0]  in_pos_x;
  logic [5:0]  in_pos_y;
  logic [3:0]  in_row_index;
  logic [4:0]  in_row_width;
  logic [15:0] in_row_pixels;
  logic        in_last_row;
  logic [12:0] in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_collision;
  logic        out_sprite_done;
  logic        out_pixel;

  xor_sprite_framebuffer #(
    .MAX_PIXELS(FB_PIXELS),
    .MAX_ROW_PIXELS(ROW_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_row_index(in_row_index),
    .in_row_width(in_row_width),
    .in_row_pixels(in_row_pixels),
    .in_last_row(in_last_row),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_collision(out_collision),
    .out_sprite_done(out_sprite_done),
    .out_pixel(out_pixel)
  );

  bit [FB_PIXELS-1:0] back_px;
  bit [FB_PIXELS-1:0] shown_px;
  bit                 hit;
  int unsigned        scr_w;
  int unsigned        scr_h;

  outcome_t    due_results [$];
  int          n_bad;
  int          n_results;
  int          n_sent;
  int          n_hits;
  int          n_lit;
  int          gap_pct;
  int          hold_pct;
  bit          squeeze;
  bit          squeeze_done;
  int unsigned last_base;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void wipe_frame();
    back_px = '0;
    shown_px = '0;
    hit = 1'b0;
  endfunction

  function automatic outcome_t frame_step(beat_t b);
    outcome_t    r;
    int unsigned size;
    int unsigned base;
    int unsigned a;
    int unsigned n;
    bit          s;
    r = '0;
    size = scr_w * scr_h;
    if (size > FB_PIXELS) size = FB_PIXELS;
    case (b.kind)
      xsf_pkg::KIND_DRAW: begin
        base = scr_w * (32'(b.py) + 32'(b.row)) + 32'(b.px);
        n = (b.rw > ROW_MAX) ? ROW_MAX : 32'(b.rw);
        for (int j = 0; j < n; j++) begin
          a = base + j;
          s = b.bits[j];
          if (a < size) begin
            back_px[a] = back_px[a] ^ s;
            if (back_px[a] == xsf_pkg::PX_DARK && s == xsf_pkg::PX_LIT) hit = 1'b1;
          end
        end
        r.coll = hit;
        r.done = b.last;
        if (b.last) hit = 1'b0;
      end
      xsf_pkg::KIND_CLEAR: back_px = '0;
      xsf_pkg::KIND_PRESENT: shown_px = back_px;
      default: begin
        if (32'(b.ridx) < size) r.pix = shown_px[b.ridx];
      end
    endcase
    return r;
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    b.kind = xsf_pkg::kind_t'($urandom_range(0, 3));
    b.px = 7'($urandom);
    b.py = 6'($urandom);
    b.row = 4'($urandom);
    b.rw = 5'($urandom);
    b.bits = 16'($urandom);
    b.last = 1'($urandom);
    b.ridx = 13'($urandom);
    return b;
  endfunction

  task automatic report_mismatch(string field, logic got, logic want);
    if (n_bad < SHOW_MAX) begin
      $display("result %0d: %s is %b, expected %b", n_results, field, got, want);
    end
    n_bad++;
  endtask

  task automatic offer_beat(beat_t b, logic fixed, outcome_t want);
    outcome_t r;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_pos_x <= b.px;
    in_pos_y <= b.py;
    in_row_index <= b.row;
    in_row_width <= b.rw;
    in_row_pixels <= b.bits;
    in_last_row <= b.last;
    in_read_index <= b.ridx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = frame_step(b);
    due_results.push_back(fixed ? want : r);
    n_sent++;
  endtask

  task automatic write_reg(xsf_pkg::cfg_reg_t idx, logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == xsf_pkg::CFG_SCREEN_WIDTH) scr_w = v;
    else scr_h = v[6:0];
    wipe_frame();
    repeat (2) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic random_phase(int phase_no);
    beat_t       b;
    int          sent;
    int          pick;
    int          rows;
    bit          broken;
    logic [6:0]  x;
    logic [5:0]  y;
    sent = 0;
    while (sent < RAND_PER_PHASE) begin
      if (phase_no == 1 && sent >= 40 && !squeeze_done) begin
        squeeze = 1'b1;
        squeeze_done = 1'b1;
      end
      b = rand_beat();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rows = $urandom_range(1, 16);
        broken = ($urandom_range(0, 9) == 0);
        x = (scr_w > 0 && $urandom_range(0, 1)) ?
            7'($urandom_range(0, scr_w > 128 ? 127 : scr_w - 1)) : 7'($urandom);
        y = (scr_h > 0 && $urandom_range(0, 1)) ?
            6'($urandom_range(0, scr_h > 64 ? 63 : scr_h - 1)) : 6'($urandom);
        last_base = scr_w * y + x;
        for (int r = 0; r < rows; r++) begin
          b = rand_beat();
          b.kind = xsf_pkg::KIND_DRAW;
          b.px = x;
          b.py = y;
          pick = $urandom_range(0, 9);
          if (pick == 0) b.rw = 5'd0;
          else if (pick == 1) b.rw = 5'($urandom_range(ROW_MAX + 1, 31));
          else b.rw = 5'($urandom_range(1, ROW_MAX));
          if (!broken) begin
            b.row = 4'(r);
            b.last = (r == rows - 1);
          end
          offer_beat(b, 1'b0, '0);
        end
        sent += rows;
      end else begin
        if (pick < 80) begin
          b.kind = xsf_pkg::KIND_READ;
          if ($urandom_range(0, 1)) b.ridx = 13'(last_base + $urandom_range(0, 40));
        end else if (pick < 86) begin
          b.kind = xsf_pkg::KIND_PRESENT;
        end else if (pick < 89) begin
          b.kind = xsf_pkg::KIND_CLEAR;
        end
        offer_beat(b, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < hold_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected beat", 1'b1, 1'b0);
      end else begin
        e = due_results.pop_front();
        if (out_collision !== e.coll) report_mismatch("collision", out_collision, e.coll);
        if (out_sprite_done !== e.done) report_mismatch("sprite_done", out_sprite_done, e.done);
        if (out_pixel !== e.pix) report_mismatch("pixel", out_pixel, e.pix);
        if (out_collision === 1'b1) n_hits++;
        if (out_pixel === 1'b1) n_lit++;
      end
      n_results++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= xsf_pkg::CFG_SCREEN_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_kind <= xsf_pkg::KIND_DRAW;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_row_index <= '0;
    in_row_width <= '0;
    in_row_pixels <= '0;
    in_last_row <= 1'b0;
    in_read_index <= '0;
    out_stall <= 1'b0;
    n_bad = 0;
    n_results = 0;
    n_sent = 0;
    n_hits = 0;
    n_lit = 0;
    squeeze = 1'b0;
    squeeze_done = 1'b0;
    last_base = 0;
    gap_pct = 10;
    hold_pct = 10;
    scr_w = xsf_pkg::SCREEN_WIDTH_RST;
    scr_h = xsf_pkg::SCREEN_HEIGHT_RST;
    wipe_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_N; i++) offer_beat(PLAN[i].b, PLAN[i].fixed, PLAN[i].want);
    random_phase(0);
    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      write_reg(xsf_pkg::CFG_SCREEN_WIDTH, 8'(SET_W[p]));
      write_reg(xsf_pkg::CFG_SCREEN_HEIGHT, 8'(SET_H[p]));
      gap_pct = GAP_PCT[p];
      hold_pct = HOLD_PCT[p];
      random_phase(p + 1);
    end
    drain(20);
    $display("Sent %0d beats across %0d screen sizes, including zero and saturated sizes.",
             n_sent, PHASES + 1);
    $display("Saw %0d results: %0d with collision set, %0d lit pixel reads.",
             n_results, n_hits, n_lit);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/xsf_pkg.sv
design/xsf_front.sv
design/xsf_queue.sv
design/xsf_back.sv
design/xor_sprite_framebuffer.sv
test/xor_sprite_framebuffer_tb.sv
